// ----- rtl/cmo_pkg.sv -----
`default_nettype none
package cmo_pkg;

   localparam int SAMPLE_BITS  = 32;
   localparam int MAX_PERIOD   = 256;
   localparam int CFG_W        = 9;
   localparam int PERIOD_RESET = 14;
   localparam int SCALE        = 10000;
   localparam int CMO_W        = 15;

   localparam int MOVE_W  = SAMPLE_BITS + 1;
   localparam int RING_AW = (MAX_PERIOD > 1) ? $clog2(MAX_PERIOD) : 1;
   localparam int CNT_W   = $clog2(MAX_PERIOD + 1);
   localparam int SUM_W   = SAMPLE_BITS + $clog2(MAX_PERIOD);
   localparam int Q_W     = $clog2(SCALE + 1);
   localparam int PROD_W  = SUM_W + Q_W;
   localparam int DIV_CW  = $clog2(Q_W);
   localparam int CMP_W   = (CFG_W > CNT_W) ? CFG_W : CNT_W;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MOVE,
      ST_RETIRE,
      ST_ADD,
      ST_DIFF,
      ST_ABS,
      ST_SCALE,
      ST_DIVIDE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic capture;
      logic start;
      logic retire;
      logic add_move;
      logic diff;
      logic absval;
      logic scale;
      logic div_step;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic first;
      logic full;
      logic sum_zero;
   } status_type;

   // period 0 acts as 1, above the ring depth acts as the depth
   function automatic logic [CNT_W-1:0] eff_period(input logic [CFG_W-1:0] p);
      logic [CMP_W-1:0] pw;
      pw = CMP_W'(p);
      if (pw == '0) begin
         return CNT_W'(1);
      end
      if (pw > CMP_W'(MAX_PERIOD)) begin
         return CNT_W'(MAX_PERIOD);
      end
      return CNT_W'(pw);
   endfunction

endpackage
`default_nettype wire

// ----- rtl/cmo_req_if.sv -----
`default_nettype none
interface cmo_req_if import cmo_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [SAMPLE_BITS-1:0] sample;
   logic                   new_series;

   modport source (output valid, output sample, output new_series, input ready);
   modport sink   (input valid, input sample, input new_series, output ready);
endinterface
`default_nettype wire

// ----- rtl/cmo_rsp_if.sv -----
`default_nettype none
interface cmo_rsp_if import cmo_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [CMO_W-1:0] cmo_hundredths;
   logic                    undefined;

   modport source (output valid, output cmo_hundredths, output undefined, input ready);
   modport sink   (input valid, input cmo_hundredths, input undefined, output ready);
endinterface
`default_nettype wire

// ----- rtl/cmo_csr_if.sv -----
`default_nettype none
interface cmo_csr_if import cmo_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [CFG_W-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/cmo_ram.sv -----
`default_nettype none
module cmo_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ----- rtl/cmo_ctrl.sv -----
`default_nettype none
module cmo_ctrl import cmo_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       rsp_ready,
   output logic       rsp_valid,
   input  status_type status,
   output cmd_type    cmd
);

   state_type         state_ff, state_in;
   logic [DIV_CW-1:0] cnt_ff, cnt_in;
   logic              rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_MOVE;
            end
         end
         ST_MOVE: begin
            cmd.start = 1'b1;
            state_in  = status.first ? ST_IDLE : ST_RETIRE;
         end
         ST_RETIRE: begin
            cmd.retire = 1'b1;
            state_in   = ST_ADD;
         end
         ST_ADD: begin
            cmd.add_move = 1'b1;
            state_in     = status.full ? ST_DIFF : ST_IDLE;
         end
         ST_DIFF: begin
            cmd.diff = 1'b1;
            state_in = ST_ABS;
         end
         ST_ABS: begin
            cmd.absval = 1'b1;
            state_in   = ST_SCALE;
         end
         ST_SCALE: begin
            cmd.scale = 1'b1;
            cnt_in    = '0;
            state_in  = status.sum_zero ? ST_DONE : ST_DIVIDE;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == DIV_CW'(Q_W - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

// ----- rtl/cmo_dp.sv -----
`default_nettype none
module cmo_dp import cmo_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  cmd_type                 cmd,
   output status_type              status,
   input  logic [SAMPLE_BITS-1:0]  req_sample,
   input  logic                    req_new_series,
   input  logic                    cfg_wr,
   input  logic [CFG_W-1:0]        cfg_data,
   output logic signed [CMO_W-1:0] rsp_cmo,
   output logic                    rsp_undefined
);

   localparam int EXT_W = CNT_W + 1;

   logic [CFG_W-1:0]        period_ff, period_in;
   logic [SAMPLE_BITS-1:0]  prev_ff, prev_in;
   logic                    prev_valid_ff, prev_valid_in;
   logic [SUM_W-1:0]        up_ff, up_in;
   logic [SUM_W-1:0]        down_ff, down_in;
   logic [CNT_W-1:0]        fill_ff, fill_in;
   logic [RING_AW-1:0]      pos_ff, pos_in;

   logic [SAMPLE_BITS-1:0]  s_ff;
   logic                    ns_ff;
   logic signed [MOVE_W-1:0] mv_ff;
   logic [SUM_W-1:0]        sum_ff;
   logic signed [SUM_W:0]   diff_ff;
   logic [SUM_W-1:0]        mag_ff;
   logic                    neg_ff;
   logic                    undef_ff;
   logic [SUM_W-1:0]        rem_ff;
   logic [Q_W-1:0]          low_ff;
   logic signed [CMO_W-1:0] cmo_ff;
   logic                    rsp_undef_ff;

   logic [CNT_W-1:0]        eff;
   logic                    first;
   logic                    full;
   logic [EXT_W-1:0]        pos_x, eff_x;
   logic [RING_AW-1:0]      old_addr;
   logic [MOVE_W-1:0]       ram_rd;
   logic signed [MOVE_W-1:0] om;
   logic [PROD_W-1:0]       prod;
   logic [SUM_W:0]          trial;
   logic                    ge;

   assign eff   = eff_period(period_ff);
   assign first = ns_ff || !prev_valid_ff;
   assign full  = (fill_ff >= eff);

   assign status.first    = first;
   assign status.full     = full;
   assign status.sum_zero = (sum_ff == '0);

   // slot of the move that leaves the window
   assign pos_x = EXT_W'(pos_ff);
   assign eff_x = EXT_W'(eff);
   always_comb begin
      if (pos_x >= eff_x) begin
         old_addr = RING_AW'(pos_x - eff_x);
      end else begin
         old_addr = RING_AW'(pos_x + EXT_W'(MAX_PERIOD) - eff_x);
      end
   end

   cmo_ram #(
      .WIDTH (MOVE_W),
      .DEPTH (MAX_PERIOD)
   ) u_ring (
      .clock   (clock),
      .wr_en   (cmd.retire),
      .wr_addr (pos_ff),
      .wr_data (mv_ff),
      .rd_en   (cmd.start),
      .rd_addr (old_addr),
      .rd_data (ram_rd)
   );

   assign om = $signed(ram_rd);

   always_comb begin
      period_in     = period_ff;
      prev_in       = prev_ff;
      prev_valid_in = prev_valid_ff;
      up_in         = up_ff;
      down_in       = down_ff;
      fill_in       = fill_ff;
      pos_in        = pos_ff;
      if (cfg_wr) begin
         period_in = cfg_data;
         up_in     = '0;
         down_in   = '0;
         fill_in   = '0;
      end else if (cmd.start) begin
         prev_in = s_ff;
         if (first) begin
            prev_valid_in = 1'b1;
            up_in         = '0;
            down_in       = '0;
            fill_in       = '0;
         end
      end else if (cmd.retire) begin
         pos_in = (pos_ff == RING_AW'(MAX_PERIOD - 1)) ? '0 : pos_ff + 1'b1;
         if (full) begin
            if (!om[MOVE_W-1] && (om != '0)) begin
               up_in = up_ff - SUM_W'(om[SAMPLE_BITS-1:0]);
            end else if (om[MOVE_W-1]) begin
               down_in = down_ff + SUM_W'(om);
            end
         end else begin
            fill_in = fill_ff + 1'b1;
         end
      end else if (cmd.add_move) begin
         if (!mv_ff[MOVE_W-1] && (mv_ff != '0)) begin
            up_in = up_ff + SUM_W'(mv_ff[SAMPLE_BITS-1:0]);
         end else if (mv_ff[MOVE_W-1]) begin
            down_in = down_ff - SUM_W'(mv_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff     <= CFG_W'(PERIOD_RESET);
         prev_ff       <= '0;
         prev_valid_ff <= 1'b0;
         up_ff         <= '0;
         down_ff       <= '0;
         fill_ff       <= '0;
         pos_ff        <= '0;
      end else begin
         period_ff     <= period_in;
         prev_ff       <= prev_in;
         prev_valid_ff <= prev_valid_in;
         up_ff         <= up_in;
         down_ff       <= down_in;
         fill_ff       <= fill_in;
         pos_ff        <= pos_in;
      end
   end

   assign prod  = PROD_W'(mag_ff) * PROD_W'(SCALE);
   assign trial = {rem_ff, low_ff[Q_W-1]};
   assign ge    = (trial >= {1'b0, sum_ff});

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         s_ff  <= req_sample;
         ns_ff <= req_new_series;
      end
      if (cmd.start) begin
         mv_ff <= $signed({1'b0, s_ff}) - $signed({1'b0, prev_ff});
      end
      if (cmd.diff) begin
         sum_ff  <= SUM_W'(up_ff + down_ff);
         diff_ff <= $signed({1'b0, up_ff}) - $signed({1'b0, down_ff});
      end
      if (cmd.absval) begin
         neg_ff <= diff_ff[SUM_W];
         mag_ff <= diff_ff[SUM_W] ? SUM_W'(-diff_ff) : diff_ff[SUM_W-1:0];
      end
      // restoring division: numerator bits shift out of low_ff as quotient bits shift in
      if (cmd.scale) begin
         undef_ff <= (sum_ff == '0);
         rem_ff   <= prod[PROD_W-1:Q_W];
         low_ff   <= prod[Q_W-1:0];
      end else if (cmd.div_step) begin
         rem_ff <= ge ? SUM_W'(trial - {1'b0, sum_ff}) : trial[SUM_W-1:0];
         low_ff <= {low_ff[Q_W-2:0], ge};
      end
      if (cmd.load_rsp) begin
         rsp_undef_ff <= undef_ff;
         if (undef_ff) begin
            cmo_ff <= '0;
         end else if (neg_ff) begin
            cmo_ff <= -$signed(CMO_W'(low_ff));
         end else begin
            cmo_ff <= $signed(CMO_W'(low_ff));
         end
      end
   end

   assign rsp_cmo       = cmo_ff;
   assign rsp_undefined = rsp_undef_ff;

endmodule
`default_nettype wire

// ----- rtl/chande_momentum_oscillator_top.sv -----
// A request passes through MOVE, RETIRE, ADD, DIFF, ABS, SCALE, DIVIDE (14-step divider)
//   and DONE; DIVIDE is skipped when both sums are zero. The first sample of a series stops
//   after MOVE and warm-up after ADD, with no result. A new request is taken only in IDLE.
// A finished result waits in the output register while the next request is taken.
// Reset (synchronous, active high) clears period to 14, sums, fill count and ring position;
//   the move ring itself is not cleared.
`default_nettype none
module chande_momentum_oscillator_top import cmo_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   cmo_req_if.sink   req_ch,
   cmo_rsp_if.source rsp_ch,
   cmo_csr_if.sink   csr_ch
);

   cmd_type    cmd;
   status_type status;

   // period writes only between requests
   assign csr_ch.ready = req_ch.ready;

   cmo_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_ready (rsp_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .status    (status),
      .cmd       (cmd)
   );

   cmo_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_sample     (req_ch.sample),
      .req_new_series (req_ch.new_series),
      .cfg_wr         (csr_ch.valid && csr_ch.ready),
      .cfg_data       (csr_ch.data),
      .rsp_cmo        (rsp_ch.cmo_hundredths),
      .rsp_undefined  (rsp_ch.undefined)
   );

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> !req_ch.ready)
      else $error("request taken while previous one in progress");

   a_load_shows_result: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |=> rsp_ch.valid)
      else $error("loaded result not presented");

   a_cfg_restarts_window: assert property (@(posedge clock) disable iff (reset)
      (csr_ch.valid && csr_ch.ready) |=> !status.full)
      else $error("window not restarted by period write");

endmodule
`default_nettype wire
